// ===== src/rtt_jitter_loss_stats_unit_assert.svh =====
// Assertion macros shared by the checker of the rtt jitter/loss statistics unit.
// Needs signals named clk and rst at the place of use.
`ifndef RTT_JITTER_LOSS_STATS_UNIT_ASSERT_SVH
`define RTT_JITTER_LOSS_STATS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RJLS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RJLS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rjls_pkg.sv =====
// Shared constants, types and the microcode ROM of the rtt jitter/loss statistics unit.
// No dependencies; used by every other file of the block but the assertion header.
package rjls_pkg;

  localparam int RTT_BITS       = 24;
  localparam int COUNT_BITS     = 32;
  localparam int SUM_BITS       = 56;
  localparam int LOSS_BITS      = 14;
  localparam int QUAL_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = RTT_BITS;
  localparam int PROD_BITS      = COUNT_BITS + RTT_BITS;
  localparam int CMP_BITS       = (SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS;
  localparam int DIV_STEPS      = SUM_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
  localparam int BP_SCALE       = 10000;

  localparam int IN_DATA_BITS   = ((RTT_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COUNT_BITS + 5 * RTT_BITS + LOSS_BITS + QUAL_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [LOSS_BITS-1:0] LOSS_LIMIT_RESET = LOSS_BITS'(500);
  localparam logic [RTT_BITS-1:0]  JIT_POOR_RESET   = RTT_BITS'(50000);
  localparam logic [RTT_BITS-1:0]  JIT_FAIR_RESET   = RTT_BITS'(20000);
  localparam logic [RTT_BITS-1:0]  JIT_GOOD_RESET   = RTT_BITS'(10000);

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOSS_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JIT_POOR   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JIT_FAIR   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JIT_GOOD   = 2'd3;

  // Quality codes
  localparam logic [QUAL_BITS-1:0] Q_EXCELLENT   = 3'd0;
  localparam logic [QUAL_BITS-1:0] Q_GOOD        = 3'd1;
  localparam logic [QUAL_BITS-1:0] Q_FAIR        = 3'd2;
  localparam logic [QUAL_BITS-1:0] Q_POOR_JITTER = 3'd3;
  localparam logic [QUAL_BITS-1:0] Q_POOR_LOSS   = 3'd4;

  localparam int PC_BITS = 5;
  typedef logic [PC_BITS-1:0] pc_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_LD_RTT,
    OP_LD_JIT,
    OP_LD_LOSS,
    OP_DIV,
    OP_ST_RTT,
    OP_ST_JIT,
    OP_ST_LOSS,
    OP_MUL_LOST,
    OP_MUL_LIM,
    OP_MUL_POOR,
    OP_MUL_FAIR,
    OP_MUL_GOOD,
    OP_CMP_LOSS,
    OP_CMP_POOR,
    OP_CMP_FAIR,
    OP_CMP_GOOD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_DIV_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic div_last;
  } seq_stat_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic last;
    logic zero;
  } div_stat_t;

  // Program addresses
  localparam pc_t A_TAKE     = pc_t'(0);
  localparam pc_t A_LD_RTT   = pc_t'(1);
  localparam pc_t A_DV_RTT   = pc_t'(2);
  localparam pc_t A_ST_RTT   = pc_t'(3);
  localparam pc_t A_LD_JIT   = pc_t'(4);
  localparam pc_t A_DV_JIT   = pc_t'(5);
  localparam pc_t A_ST_JIT   = pc_t'(6);
  localparam pc_t A_MUL_LOST = pc_t'(7);
  localparam pc_t A_LD_LOSS  = pc_t'(8);
  localparam pc_t A_DV_LOSS  = pc_t'(9);
  localparam pc_t A_ST_LOSS  = pc_t'(10);
  localparam pc_t A_MUL_LIM  = pc_t'(11);
  localparam pc_t A_CMP_LOSS = pc_t'(12);
  localparam pc_t A_MUL_POOR = pc_t'(13);
  localparam pc_t A_CMP_POOR = pc_t'(14);
  localparam pc_t A_MUL_FAIR = pc_t'(15);
  localparam pc_t A_CMP_FAIR = pc_t'(16);
  localparam pc_t A_MUL_GOOD = pc_t'(17);
  localparam pc_t A_CMP_GOOD = pc_t'(18);
  localparam pc_t A_EMIT     = pc_t'(19);
  localparam pc_t A_WRAP     = pc_t'(20);

  // Microcode ROM: one control word per step
  function automatic uword_t ucode(input pc_t addr);
    uword_t w;
    case (addr)
      A_TAKE:     w = '{op: OP_TAKE,     cond: COND_NO_IN,    target: A_TAKE};
      A_LD_RTT:   w = '{op: OP_LD_RTT,   cond: COND_NONE,     target: A_TAKE};
      A_DV_RTT:   w = '{op: OP_DIV,      cond: COND_DIV_MORE, target: A_DV_RTT};
      A_ST_RTT:   w = '{op: OP_ST_RTT,   cond: COND_NONE,     target: A_TAKE};
      A_LD_JIT:   w = '{op: OP_LD_JIT,   cond: COND_NONE,     target: A_TAKE};
      A_DV_JIT:   w = '{op: OP_DIV,      cond: COND_DIV_MORE, target: A_DV_JIT};
      A_ST_JIT:   w = '{op: OP_ST_JIT,   cond: COND_NONE,     target: A_TAKE};
      A_MUL_LOST: w = '{op: OP_MUL_LOST, cond: COND_NONE,     target: A_TAKE};
      A_LD_LOSS:  w = '{op: OP_LD_LOSS,  cond: COND_NONE,     target: A_TAKE};
      A_DV_LOSS:  w = '{op: OP_DIV,      cond: COND_DIV_MORE, target: A_DV_LOSS};
      A_ST_LOSS:  w = '{op: OP_ST_LOSS,  cond: COND_NONE,     target: A_TAKE};
      A_MUL_LIM:  w = '{op: OP_MUL_LIM,  cond: COND_NONE,     target: A_TAKE};
      A_CMP_LOSS: w = '{op: OP_CMP_LOSS, cond: COND_NONE,     target: A_TAKE};
      A_MUL_POOR: w = '{op: OP_MUL_POOR, cond: COND_NONE,     target: A_TAKE};
      A_CMP_POOR: w = '{op: OP_CMP_POOR, cond: COND_NONE,     target: A_TAKE};
      A_MUL_FAIR: w = '{op: OP_MUL_FAIR, cond: COND_NONE,     target: A_TAKE};
      A_CMP_FAIR: w = '{op: OP_CMP_FAIR, cond: COND_NONE,     target: A_TAKE};
      A_MUL_GOOD: w = '{op: OP_MUL_GOOD, cond: COND_NONE,     target: A_TAKE};
      A_CMP_GOOD: w = '{op: OP_CMP_GOOD, cond: COND_NONE,     target: A_TAKE};
      A_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FULL, target: A_EMIT};
      A_WRAP:     w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: A_TAKE};
      default:    w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: A_TAKE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/rjls_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle while step is high, shared by both means and the loss ratio.
// Depends on rjls_pkg.
module rjls_div (
  input  logic                          clk,
  input  logic                          rst,
  input  rjls_pkg::div_ctrl_t           ctrl,
  input  logic [rjls_pkg::SUM_BITS-1:0]   dividend,
  input  logic [rjls_pkg::COUNT_BITS-1:0] divisor,
  output logic [rjls_pkg::SUM_BITS-1:0]   quotient,
  output rjls_pkg::div_stat_t           stat
);

  logic [rjls_pkg::SUM_BITS-1:0]     acc;
  logic [rjls_pkg::COUNT_BITS-1:0]   rem;
  logic [rjls_pkg::COUNT_BITS-1:0]   dvs;
  logic [rjls_pkg::DIV_CNT_BITS-1:0] cnt;

  logic [rjls_pkg::COUNT_BITS:0] rem_sh;
  logic [rjls_pkg::COUNT_BITS:0] diff;
  logic                          take;

  always_comb begin
    rem_sh = {rem, acc[rjls_pkg::SUM_BITS-1]};
    diff   = rem_sh - {1'b0, dvs};
    take   = rem_sh >= {1'b0, dvs};
  end

  // dividend shifts out the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (ctrl.step) begin
      acc <= {acc[rjls_pkg::SUM_BITS-2:0], take};
      rem <= take ? diff[rjls_pkg::COUNT_BITS-1:0] : rem_sh[rjls_pkg::COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + rjls_pkg::DIV_CNT_BITS'(1);
    end
  end

  assign quotient  = acc;
  assign stat.last = (cnt == rjls_pkg::DIV_CNT_BITS'(rjls_pkg::DIV_STEPS - 1));
  assign stat.zero = (dvs == '0);

endmodule

// ===== src/rjls_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on rjls_pkg (control word types and ROM contents).
module rjls_seq (
  input  logic                clk,
  input  logic                rst,
  input  rjls_pkg::seq_stat_t stat,
  output rjls_pkg::uword_t    uw
);

  rjls_pkg::pc_t pc;
  rjls_pkg::pc_t pc_next;
  logic          jump;

  assign uw = rjls_pkg::ucode(pc);

  always_comb begin
    case (uw.cond)
      rjls_pkg::COND_NONE:     jump = 1'b0;
      rjls_pkg::COND_ALWAYS:   jump = 1'b1;
      rjls_pkg::COND_NO_IN:    jump = !stat.in_valid;
      rjls_pkg::COND_DIV_MORE: jump = !stat.div_last;
      rjls_pkg::COND_OUT_FULL: jump = stat.out_full;
      default:                 jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = jump ? uw.target : pc + rjls_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rjls_pkg::A_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/rtt_jitter_loss_stats_unit.sv =====
// Probe round-trip statistics unit: counts, min/max/last/mean rtt, mean jitter,
// loss in basis points and a quality code. Depends on rjls_pkg, rjls_seq, rjls_div.
//
// One probe outcome enters per slave transfer (tuser = reply flag, tdata = rtt in
// microseconds) and exactly one statistics record leaves per master transfer.
// Running state (counts, min, max, last, saturating 56-bit sums) updates in the
// cycle the probe is taken. A microcoded sequencer then drives a single radix-2
// divider through three 56-step passes (mean rtt, mean jitter, loss), and one
// 32x24 multiplier with a registered compare for the four quality thresholds.
// A probe occupies the block from transfer in until its record is emitted and the
// sequencer is back at take; the three divider passes fill most of that span, and a stalled
// output holds the block at emit only when the previous record is still waiting.
// The output register lets the next probe be taken while the last record waits.
// Configuration writes take effect at once and are meant for idle periods.
module rtt_jitter_loss_stats_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side: probe outcome
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rjls_pkg::IN_DATA_BITS-1:0]    s_tdata,   // [23:0] rtt_us
  input  logic                                 s_tuser,   // [0] reply_received
  // master side: statistics record
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [31:0] sent_count, [63:32] received_count, [87:64] min_rtt_us,
  // [111:88] max_rtt_us, [135:112] rtt of the latest reply, [159:136] mean_rtt_us,
  // [183:160] mean_jitter_us, [197:184] loss_bp, [200:198] quality, rest zero
  output logic [rjls_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [rjls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rjls_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int SUMX_BITS = rjls_pkg::SUM_BITS + 1;

  // configuration registers
  logic [rjls_pkg::LOSS_BITS-1:0] loss_limit;
  logic [rjls_pkg::RTT_BITS-1:0]  jit_poor;
  logic [rjls_pkg::RTT_BITS-1:0]  jit_fair;
  logic [rjls_pkg::RTT_BITS-1:0]  jit_good;

  // running statistics
  logic [rjls_pkg::COUNT_BITS-1:0] sent, sent_next;
  logic [rjls_pkg::COUNT_BITS-1:0] recv, recv_next;
  logic [rjls_pkg::COUNT_BITS-1:0] jcnt, jcnt_next;
  logic [rjls_pkg::RTT_BITS-1:0]   rtt_min, rtt_min_next;
  logic [rjls_pkg::RTT_BITS-1:0]   rtt_max, rtt_max_next;
  logic [rjls_pkg::RTT_BITS-1:0]   rtt_last, rtt_last_next;
  logic [rjls_pkg::SUM_BITS-1:0]   rtt_sum, rtt_sum_next;
  logic [rjls_pkg::SUM_BITS-1:0]   jit_sum, jit_sum_next;

  // datapath work registers
  logic [rjls_pkg::PROD_BITS-1:0]  prod;
  logic [rjls_pkg::PROD_BITS-1:0]  lost_scaled;
  logic [rjls_pkg::RTT_BITS-1:0]   mean_rtt;
  logic [rjls_pkg::RTT_BITS-1:0]   mean_jit;
  logic [rjls_pkg::LOSS_BITS-1:0]  loss_bp;
  logic                            q_loss, q_poor, q_fair, q_good;

  // sequencer and divider hookup
  rjls_pkg::uword_t    uw;
  rjls_pkg::seq_stat_t seq_stat;
  rjls_pkg::div_ctrl_t div_ctrl;
  rjls_pkg::div_stat_t div_stat;
  logic [rjls_pkg::SUM_BITS-1:0]   div_dividend;
  logic [rjls_pkg::COUNT_BITS-1:0] div_divisor;
  logic [rjls_pkg::SUM_BITS-1:0]   div_quot;

  logic                            in_take;
  logic                            out_free;
  logic                            out_load;
  logic [rjls_pkg::RTT_BITS-1:0]   rtt_in;
  logic [rjls_pkg::RTT_BITS-1:0]   jit_diff;
  logic [SUMX_BITS-1:0]            jit_sum_ext;
  logic [SUMX_BITS-1:0]            rtt_sum_ext;
  logic [rjls_pkg::COUNT_BITS-1:0] lost;
  logic [rjls_pkg::COUNT_BITS-1:0] mul_a;
  logic [rjls_pkg::RTT_BITS-1:0]   mul_b;
  logic [rjls_pkg::PROD_BITS-1:0]  mul_res;
  logic [rjls_pkg::RTT_BITS-1:0]   quot_mean;
  logic [rjls_pkg::QUAL_BITS-1:0]  quality;

  rjls_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (seq_stat),
    .uw   (uw)
  );

  rjls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------- handshake
  // no transfer is taken while reset is held
  assign s_tready = !rst && (uw.op == rjls_pkg::OP_TAKE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (uw.op == rjls_pkg::OP_EMIT) && out_free;

  always_comb begin
    seq_stat.in_valid = s_tvalid;
    seq_stat.out_full = !out_free;
    seq_stat.div_last = div_stat.last;
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_limit <= rjls_pkg::LOSS_LIMIT_RESET;
      jit_poor   <= rjls_pkg::JIT_POOR_RESET;
      jit_fair   <= rjls_pkg::JIT_FAIR_RESET;
      jit_good   <= rjls_pkg::JIT_GOOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rjls_pkg::CFG_LOSS_LIMIT: loss_limit <= cfg_data[rjls_pkg::LOSS_BITS-1:0];
        rjls_pkg::CFG_JIT_POOR:   jit_poor   <= cfg_data[rjls_pkg::RTT_BITS-1:0];
        rjls_pkg::CFG_JIT_FAIR:   jit_fair   <= cfg_data[rjls_pkg::RTT_BITS-1:0];
        rjls_pkg::CFG_JIT_GOOD:   jit_good   <= cfg_data[rjls_pkg::RTT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- probe update
  // Counts and sums saturate: counters at all ones, sums at 2^56-1.
  always_comb begin
    rtt_in      = s_tdata[rjls_pkg::RTT_BITS-1:0];
    jit_diff    = (rtt_in > rtt_last) ? rtt_in - rtt_last : rtt_last - rtt_in;
    jit_sum_ext = {1'b0, jit_sum} + SUMX_BITS'(jit_diff);
    rtt_sum_ext = {1'b0, rtt_sum} + SUMX_BITS'(rtt_in);

    sent_next     = (sent == '1) ? sent : sent + rjls_pkg::COUNT_BITS'(1);
    recv_next     = recv;
    jcnt_next     = jcnt;
    jit_sum_next  = jit_sum;
    rtt_sum_next  = rtt_sum;
    rtt_last_next = rtt_last;
    rtt_min_next  = rtt_min;
    rtt_max_next  = rtt_max;

    if (s_tuser) begin
      // first reply has no predecessor, so no jitter sample
      if (recv != '0) begin
        jit_sum_next = jit_sum_ext[rjls_pkg::SUM_BITS] ? '1 :
                       jit_sum_ext[rjls_pkg::SUM_BITS-1:0];
        jcnt_next    = (jcnt == '1) ? jcnt : jcnt + rjls_pkg::COUNT_BITS'(1);
      end
      recv_next     = (recv == '1) ? recv : recv + rjls_pkg::COUNT_BITS'(1);
      rtt_last_next = rtt_in;
      rtt_sum_next  = rtt_sum_ext[rjls_pkg::SUM_BITS] ? '1 :
                      rtt_sum_ext[rjls_pkg::SUM_BITS-1:0];
      if (rtt_in < rtt_min) rtt_min_next = rtt_in;
      if (rtt_in > rtt_max) rtt_max_next = rtt_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent     <= '0;
      recv     <= '0;
      jcnt     <= '0;
      jit_sum  <= '0;
      rtt_sum  <= '0;
      rtt_last <= '0;
      rtt_min  <= '1;
      rtt_max  <= '0;
    end else if (in_take) begin
      sent     <= sent_next;
      recv     <= recv_next;
      jcnt     <= jcnt_next;
      jit_sum  <= jit_sum_next;
      rtt_sum  <= rtt_sum_next;
      rtt_last <= rtt_last_next;
      rtt_min  <= rtt_min_next;
      rtt_max  <= rtt_max_next;
    end
  end

  // ---------------------------------------------------------------- multiplier
  // received never passes sent, so the plain difference is the lost count
  assign lost = sent - recv;

  always_comb begin
    case (uw.op)
      rjls_pkg::OP_MUL_LOST: begin
        mul_a = lost;
        mul_b = rjls_pkg::RTT_BITS'(rjls_pkg::BP_SCALE);
      end
      rjls_pkg::OP_MUL_LIM: begin
        mul_a = sent;
        mul_b = rjls_pkg::RTT_BITS'(loss_limit);
      end
      rjls_pkg::OP_MUL_POOR: begin
        mul_a = jcnt;
        mul_b = jit_poor;
      end
      rjls_pkg::OP_MUL_FAIR: begin
        mul_a = jcnt;
        mul_b = jit_fair;
      end
      rjls_pkg::OP_MUL_GOOD: begin
        mul_a = jcnt;
        mul_b = jit_good;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // ---------------------------------------------------------------- divider feed
  always_comb begin
    div_ctrl.load = 1'b0;
    div_ctrl.step = (uw.op == rjls_pkg::OP_DIV);
    case (uw.op)
      rjls_pkg::OP_LD_RTT: begin
        div_ctrl.load = 1'b1;
        div_dividend  = rtt_sum;
        div_divisor   = recv;
      end
      rjls_pkg::OP_LD_JIT: begin
        div_ctrl.load = 1'b1;
        div_dividend  = jit_sum;
        div_divisor   = jcnt;
      end
      rjls_pkg::OP_LD_LOSS: begin
        div_ctrl.load = 1'b1;
        div_dividend  = rjls_pkg::SUM_BITS'(prod);
        div_divisor   = sent;
      end
      default: begin
        div_dividend  = rtt_sum;
        div_divisor   = recv;
      end
    endcase
  end

  // empty divisor reads as zero; a mean beyond the rtt field clamps to all ones
  always_comb begin
    if (div_stat.zero) begin
      quot_mean = '0;
    end else if (|div_quot[rjls_pkg::SUM_BITS-1:rjls_pkg::RTT_BITS]) begin
      quot_mean = '1;
    end else begin
      quot_mean = div_quot[rjls_pkg::RTT_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- results
  always_ff @(posedge clk) begin
    case (uw.op)
      rjls_pkg::OP_MUL_LOST, rjls_pkg::OP_MUL_LIM, rjls_pkg::OP_MUL_POOR,
      rjls_pkg::OP_MUL_FAIR, rjls_pkg::OP_MUL_GOOD: begin
        prod <= mul_res;
      end
      rjls_pkg::OP_LD_LOSS: lost_scaled <= prod;
      rjls_pkg::OP_ST_RTT:  mean_rtt    <= quot_mean;
      rjls_pkg::OP_ST_JIT:  mean_jit    <= quot_mean;
      // loss never exceeds 10000 bp, so the low bits carry it all
      rjls_pkg::OP_ST_LOSS: loss_bp     <= quot_mean[rjls_pkg::LOSS_BITS-1:0];
      // thresholds are compared on exact ratios, not on the truncated means
      rjls_pkg::OP_CMP_LOSS: q_loss <= (sent != '0) && (lost_scaled > prod);
      rjls_pkg::OP_CMP_POOR: q_poor <= rjls_pkg::CMP_BITS'(jit_sum) > rjls_pkg::CMP_BITS'(prod);
      rjls_pkg::OP_CMP_FAIR: q_fair <= rjls_pkg::CMP_BITS'(jit_sum) > rjls_pkg::CMP_BITS'(prod);
      rjls_pkg::OP_CMP_GOOD: q_good <= rjls_pkg::CMP_BITS'(jit_sum) > rjls_pkg::CMP_BITS'(prod);
      default: ;
    endcase
  end

  // priority: poor loss, poor jitter, fair, good, excellent
  always_comb begin
    if (q_loss) begin
      quality = rjls_pkg::Q_POOR_LOSS;
    end else if (q_poor) begin
      quality = rjls_pkg::Q_POOR_JITTER;
    end else if (q_fair) begin
      quality = rjls_pkg::Q_FAIR;
    end else if (q_good) begin
      quality = rjls_pkg::Q_GOOD;
    end else begin
      quality = rjls_pkg::Q_EXCELLENT;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rjls_pkg::OUT_DATA_BITS'({quality, loss_bp, mean_jit, mean_rtt,
                                           rtt_last, rtt_max, rtt_min, recv, sent});
    end
  end

endmodule

// ===== src/rjls_checker.sv =====
// Port-level assertion checker for rtt_jitter_loss_stats_unit, bound to the top.
// Depends on rjls_pkg and rtt_jitter_loss_stats_unit_assert.svh.
`include "rtt_jitter_loss_stats_unit_assert.svh"

module rjls_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [rjls_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  localparam int RECV_LSB = rjls_pkg::COUNT_BITS;
  localparam int MIN_LSB  = 2 * rjls_pkg::COUNT_BITS;
  localparam int MAX_LSB  = MIN_LSB + rjls_pkg::RTT_BITS;
  localparam int LOSS_LSB = MIN_LSB + 5 * rjls_pkg::RTT_BITS;
  localparam int QUAL_LSB = LOSS_LSB + rjls_pkg::LOSS_BITS;

  logic [rjls_pkg::COUNT_BITS-1:0] sent_f;
  logic [rjls_pkg::COUNT_BITS-1:0] recv_f;
  logic [rjls_pkg::RTT_BITS-1:0]   min_f;
  logic [rjls_pkg::RTT_BITS-1:0]   max_f;
  logic [rjls_pkg::LOSS_BITS-1:0]  loss_f;
  logic [rjls_pkg::QUAL_BITS-1:0]  qual_f;

  assign sent_f = m_tdata[rjls_pkg::COUNT_BITS-1:0];
  assign recv_f = m_tdata[RECV_LSB +: rjls_pkg::COUNT_BITS];
  assign min_f  = m_tdata[MIN_LSB +: rjls_pkg::RTT_BITS];
  assign max_f  = m_tdata[MAX_LSB +: rjls_pkg::RTT_BITS];
  assign loss_f = m_tdata[LOSS_LSB +: rjls_pkg::LOSS_BITS];
  assign qual_f = m_tdata[QUAL_LSB +: rjls_pkg::QUAL_BITS];

  `RJLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled record changed")
  `RJLS_ASSERT_NEXT(a_one_probe, s_tvalid && s_tready, !s_tready, "probe taken while busy")
  `RJLS_ASSERT_NOW(a_recv_le_sent, m_tvalid, recv_f <= sent_f, "more replies than probes")
  `RJLS_ASSERT_NOW(a_ranges, m_tvalid, (loss_f <= rjls_pkg::LOSS_BITS'(rjls_pkg::BP_SCALE)) && (qual_f <= rjls_pkg::Q_POOR_LOSS), "loss or quality out of range")
  `RJLS_ASSERT_NOW(a_min_le_max, m_tvalid && (recv_f != '0), min_f <= max_f, "min rtt above max rtt")

endmodule

bind rtt_jitter_loss_stats_unit rjls_checker u_rjls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_rtt_jitter_loss_stats_unit.sv =====
// Self-checking testbench for rtt_jitter_loss_stats_unit: probe outcomes go in on the
// slave stream and every statistics record is checked against an in-bench predictor.
// Depends on rjls_pkg and the unit's RTL; nothing else.
module tb_rtt_jitter_loss_stats_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] u64_t;

  localparam int RTT_BITS       = rjls_pkg::RTT_BITS;
  localparam int COUNT_BITS     = rjls_pkg::COUNT_BITS;
  localparam int SUM_BITS       = rjls_pkg::SUM_BITS;
  localparam int LOSS_BITS      = rjls_pkg::LOSS_BITS;
  localparam int QUAL_BITS      = rjls_pkg::QUAL_BITS;
  localparam int IN_DATA_BITS   = rjls_pkg::IN_DATA_BITS;
  localparam int OUT_DATA_BITS  = rjls_pkg::OUT_DATA_BITS;
  localparam int OUT_FIELD_BITS = rjls_pkg::OUT_FIELD_BITS;
  localparam int CFG_INDEX_BITS = rjls_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS  = rjls_pkg::CFG_DATA_BITS;
  localparam int BP_SCALE       = rjls_pkg::BP_SCALE;

  localparam u64_t RTT_MAX = (64'd1 << RTT_BITS) - 1;
  localparam u64_t CNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam u64_t SUM_MAX = (64'd1 << SUM_BITS) - 1;
  localparam u64_t LOSS_MASK = (64'd1 << LOSS_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 4000;  // one probe's full sequence plus output stalls, well covered
  localparam int PRINT_CAP = 40;

  // One statistics record as packed on m_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_DATA_BITS-OUT_FIELD_BITS-1:0] pad;
    logic [QUAL_BITS-1:0]  quality;
    logic [LOSS_BITS-1:0]  loss_bp;
    logic [RTT_BITS-1:0]   mean_jitter;
    logic [RTT_BITS-1:0]   mean_rtt;
    logic [RTT_BITS-1:0]   rtt_latest;
    logic [RTT_BITS-1:0]   max_rtt;
    logic [RTT_BITS-1:0]   min_rtt;
    logic [COUNT_BITS-1:0] received;
    logic [COUNT_BITS-1:0] sent;
  } stats_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata;    // [23:0] rtt_us
  logic s_tuser;                       // [0] reply_received
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [31:0] sent, [63:32] received, [87:64] min, [111:88] max, [135:112] latest,
  // [159:136] mean rtt, [183:160] mean jitter, [197:184] loss_bp, [200:198] quality
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Predictor copy of the running statistics and the thresholds.
  u64_t sent_cnt = 0;
  u64_t recv_cnt = 0;
  u64_t rtt_lo = RTT_MAX;
  u64_t rtt_hi = 0;
  u64_t rtt_prev = 0;
  u64_t rtt_acc = 0;
  u64_t jit_acc = 0;
  u64_t jit_cnt = 0;
  u64_t cfg_loss_lim = u64_t'(rjls_pkg::LOSS_LIMIT_RESET);
  u64_t cfg_jit_poor = u64_t'(rjls_pkg::JIT_POOR_RESET);
  u64_t cfg_jit_fair = u64_t'(rjls_pkg::JIT_FAIR_RESET);
  u64_t cfg_jit_good = u64_t'(rjls_pkg::JIT_GOOD_RESET);

  stats_t pending_stats[$];   // records predicted but not yet seen on the master side
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int err_count = 0;
  int probes_sent = 0;
  int records_checked = 0;
  int cfg_writes = 0;
  int qual_hist[5] = '{default: 0};
  int idle_cycles = 0;

  rtt_jitter_loss_stats_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic u64_t sat_add(input u64_t a, input u64_t b, input u64_t lim);
    u64_t s;
    s = a + b;
    return (s > lim || s < a) ? lim : s;
  endfunction

  // floor(sum / n), zero for n == 0, clamped to the rtt field
  function automatic logic [RTT_BITS-1:0] mean_clamped(input u64_t sum, input u64_t n);
    u64_t q;
    if (n == 0) return '0;
    q = sum / n;
    return (q > RTT_MAX) ? RTT_MAX[RTT_BITS-1:0] : q[RTT_BITS-1:0];
  endfunction

  function automatic u64_t loss_now_bp();
    if (sent_cnt == 0) return 0;
    return ((sent_cnt - recv_cnt) * BP_SCALE) / sent_cnt;
  endfunction

  // Fold one probe outcome into the running statistics and build the record.
  function automatic stats_t update_probe_stats(input logic got,
                                                input logic [RTT_BITS-1:0] rtt);
    stats_t r;
    u64_t lost;
    u64_t diff;
    u64_t bp;
    sent_cnt = sat_add(sent_cnt, 1, CNT_MAX);
    if (got) begin
      // the first reply has no predecessor, so no jitter sample
      if (recv_cnt != 0) begin
        diff = (rtt > rtt_prev) ? rtt - rtt_prev : rtt_prev - rtt;
        jit_acc = sat_add(jit_acc, diff, SUM_MAX);
        jit_cnt = sat_add(jit_cnt, 1, CNT_MAX);
      end
      recv_cnt = sat_add(recv_cnt, 1, CNT_MAX);
      rtt_prev = rtt;
      rtt_acc = sat_add(rtt_acc, rtt, SUM_MAX);
      if (rtt < rtt_lo) rtt_lo = rtt;
      if (rtt > rtt_hi) rtt_hi = rtt;
    end
    lost = (sent_cnt > recv_cnt) ? sent_cnt - recv_cnt : 0;
    bp = (sent_cnt != 0) ? (lost * BP_SCALE) / sent_cnt : 0;
    if (bp > BP_SCALE) bp = BP_SCALE;
    r = '0;
    r.sent        = sent_cnt[COUNT_BITS-1:0];
    r.received    = recv_cnt[COUNT_BITS-1:0];
    r.min_rtt     = rtt_lo[RTT_BITS-1:0];
    r.max_rtt     = rtt_hi[RTT_BITS-1:0];
    r.rtt_latest  = rtt_prev[RTT_BITS-1:0];
    r.mean_rtt    = mean_clamped(rtt_acc, recv_cnt);
    r.mean_jitter = mean_clamped(jit_acc, jit_cnt);
    r.loss_bp     = bp[LOSS_BITS-1:0];
    // thresholds compare against exact ratios, loss first
    if (sent_cnt != 0 && lost * BP_SCALE > cfg_loss_lim * sent_cnt)
      r.quality = rjls_pkg::Q_POOR_LOSS;
    else if (jit_acc > cfg_jit_poor * jit_cnt) r.quality = rjls_pkg::Q_POOR_JITTER;
    else if (jit_acc > cfg_jit_fair * jit_cnt) r.quality = rjls_pkg::Q_FAIR;
    else if (jit_acc > cfg_jit_good * jit_cnt) r.quality = rjls_pkg::Q_GOOD;
    else r.quality = rjls_pkg::Q_EXCELLENT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input u64_t got_v, input u64_t want_v);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t MISMATCH record %0d %s: got 0x%0h expected 0x%0h",
               $realtime, records_checked, what, got_v, want_v);
  endtask

  // All tasks below are entered and left just after a falling edge.
  task automatic send_probe(input logic got, input logic [RTT_BITS-1:0] rtt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= got;
    s_tdata  <= IN_DATA_BITS'(rtt);
    do @(posedge clk); while (!s_tready);
    pending_stats.push_back(update_probe_stats(got, rtt));
    probes_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding record come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input u64_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(val);
    @(negedge clk);
    case (idx)
      rjls_pkg::CFG_LOSS_LIMIT: cfg_loss_lim = val & LOSS_MASK;
      rjls_pkg::CFG_JIT_POOR:   cfg_jit_poor = val & RTT_MAX;
      rjls_pkg::CFG_JIT_FAIR:   cfg_jit_fair = val & RTT_MAX;
      rjls_pkg::CFG_JIT_GOOD:   cfg_jit_good = val & RTT_MAX;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Only called with the unit idle.
  task automatic write_thresholds(input u64_t loss_lim, input u64_t poor,
                                  input u64_t fair, input u64_t good);
    write_reg(rjls_pkg::CFG_LOSS_LIMIT, loss_lim);
    write_reg(rjls_pkg::CFG_JIT_POOR, poor);
    write_reg(rjls_pkg::CFG_JIT_FAIR, fair);
    write_reg(rjls_pkg::CFG_JIT_GOOD, good);
    cfg_we <= 1'b0;
  endtask

  // Reset thresholds: lost first probe, first reply, full-scale jump, ignored rtt.
  task automatic test_startup_defaults();
    send_probe(1'b0, RTT_BITS'($urandom));
    send_probe(1'b1, '0);
    send_probe(1'b1, RTT_MAX[RTT_BITS-1:0]);
    send_probe(1'b0, RTT_MAX[RTT_BITS-1:0]);
    send_probe(1'b1, RTT_BITS'(1000));
  endtask

  // Walk every quality code with extreme thresholds; jitter sum is nonzero by now.
  task automatic test_quality_codes();
    wait_idle();
    write_thresholds(BP_SCALE, 0, 0, 0);
    send_probe(1'b1, rtt_prev[RTT_BITS-1:0]);
    wait_idle();
    write_thresholds(BP_SCALE, RTT_MAX, 0, 0);
    send_probe(1'b1, rtt_prev[RTT_BITS-1:0]);
    wait_idle();
    write_thresholds(BP_SCALE, RTT_MAX, RTT_MAX, 0);
    send_probe(1'b1, rtt_prev[RTT_BITS-1:0]);
    wait_idle();
    write_thresholds(BP_SCALE, RTT_MAX, RTT_MAX, RTT_MAX);
    send_probe(1'b1, RTT_BITS'(2000));
    wait_idle();
    // zero loss limit: any loss at all is poor
    write_thresholds(0, RTT_MAX, RTT_MAX, RTT_MAX);
    send_probe(1'b1, RTT_BITS'(1500));
  endtask

  // Min/max tracking at the field edges and a run of losses.
  task automatic test_rtt_extremes();
    wait_idle();
    write_thresholds(u64_t'(rjls_pkg::LOSS_LIMIT_RESET), u64_t'(rjls_pkg::JIT_POOR_RESET),
                     u64_t'(rjls_pkg::JIT_FAIR_RESET), u64_t'(rjls_pkg::JIT_GOOD_RESET));
    send_probe(1'b1, RTT_BITS'(1));
    send_probe(1'b1, RTT_MAX[RTT_BITS-1:0] - 1'b1);
    send_probe(1'b1, RTT_MAX[RTT_BITS-1:0]);
    send_probe(1'b0, '0);
    send_probe(1'b0, RTT_BITS'($urandom));
    send_probe(1'b0, RTT_MAX[RTT_BITS-1:0]);
    send_probe(1'b1, '0);
  endtask

  // Blocks of mostly smooth rtt traffic; before each block the unit drains and the
  // thresholds are moved around the current loss and mean jitter so codes keep changing.
  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    int done;
    int blk;
    int loss_pct;
    u64_t mj;
    u64_t bp;
    u64_t spread;
    u64_t lim;
    u64_t good;
    u64_t fair;
    u64_t poor;
    u64_t step;
    u64_t delta;
    u64_t nxt;
    logic got;
    logic [RTT_BITS-1:0] rtt;
    done = 0;
    while (done < n_items) begin
      wait_idle();
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      mj = mean_clamped(jit_acc, jit_cnt);
      bp = loss_now_bp();
      case ($urandom_range(9))
        0: lim = 0;
        1: lim = BP_SCALE;
        2: lim = $urandom_range(BP_SCALE);
        default: begin
          lim = bp + $urandom_range(400);
          lim = (lim > 200) ? lim - 200 : 0;
          if (lim > BP_SCALE) lim = BP_SCALE;
        end
      endcase
      case ($urandom_range(9))
        0: begin good = RTT_MAX; fair = RTT_MAX; poor = RTT_MAX; end
        1: begin good = 0; fair = 0; poor = 0; end
        2: begin
          good = RTT_BITS'($urandom);
          fair = RTT_BITS'($urandom);
          poor = RTT_BITS'($urandom);
        end
        default: begin
          // ordered ladder straddling the current mean jitter
          spread = mj / 8 + 50;
          good = (mj > spread) ? mj - spread : 0;
          good = good + $urandom_range(32'(spread));
          fair = good + $urandom_range(32'(spread));
          poor = fair + $urandom_range(32'(spread));
          if (good > RTT_MAX) good = RTT_MAX;
          if (fair > RTT_MAX) fair = RTT_MAX;
          if (poor > RTT_MAX) poor = RTT_MAX;
        end
      endcase
      write_thresholds(lim, poor, fair, good);
      case ($urandom_range(4))
        0: loss_pct = 0;
        1: loss_pct = 1;
        2: loss_pct = 3;
        3: loss_pct = 8;
        default: loss_pct = 30;
      endcase
      step = ($urandom_range(3) == 0) ? 64'd100 : ((mj > 0) ? mj : 64'd1);
      if (step > (64'd1 << 23)) step = 64'd1 << 23;
      for (blk = 0; blk < 60 && done < n_items; blk++) begin
        got = ($urandom_range(99) >= loss_pct);
        case ($urandom_range(19))
          0: rtt = RTT_BITS'($urandom);
          1: rtt = $urandom_range(1) ? RTT_MAX[RTT_BITS-1:0] : '0;
          default: begin
            delta = $urandom_range(32'(2 * step));
            if ($urandom_range(1)) nxt = (rtt_prev + delta > RTT_MAX) ? RTT_MAX : rtt_prev + delta;
            else nxt = (delta > rtt_prev) ? 0 : rtt_prev - delta;
            rtt = nxt[RTT_BITS-1:0];
          end
        endcase
        if (!got) rtt = RTT_BITS'($urandom);   // noise, must be ignored
        send_probe(got, rtt);
        done++;
      end
    end
  endtask

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Every record transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_records
    stats_t got_r;
    stats_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got_r = stats_t'(m_tdata);
      if (pending_stats.size() == 0) begin
        report_mismatch("record with nothing pending", u64_t'(got_r.sent), 0);
      end else begin
        exp_r = pending_stats.pop_front();
        if (got_r.sent !== exp_r.sent)
          report_mismatch("sent_count", got_r.sent, exp_r.sent);
        if (got_r.received !== exp_r.received)
          report_mismatch("received_count", got_r.received, exp_r.received);
        if (got_r.min_rtt !== exp_r.min_rtt)
          report_mismatch("min_rtt_us", got_r.min_rtt, exp_r.min_rtt);
        if (got_r.max_rtt !== exp_r.max_rtt)
          report_mismatch("max_rtt_us", got_r.max_rtt, exp_r.max_rtt);
        if (got_r.rtt_latest !== exp_r.rtt_latest)
          report_mismatch("latest rtt", got_r.rtt_latest, exp_r.rtt_latest);
        if (got_r.mean_rtt !== exp_r.mean_rtt)
          report_mismatch("mean_rtt_us", got_r.mean_rtt, exp_r.mean_rtt);
        if (got_r.mean_jitter !== exp_r.mean_jitter)
          report_mismatch("mean_jitter_us", got_r.mean_jitter, exp_r.mean_jitter);
        if (got_r.loss_bp !== exp_r.loss_bp)
          report_mismatch("loss_bp", got_r.loss_bp, exp_r.loss_bp);
        if (got_r.quality !== exp_r.quality)
          report_mismatch("quality", got_r.quality, exp_r.quality);
        if (got_r.pad !== '0)
          report_mismatch("padding bits", got_r.pad, 0);
        if (exp_r.quality <= rjls_pkg::Q_POOR_LOSS) qual_hist[exp_r.quality]++;
        records_checked++;
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("tb_rtt_jitter_loss_stats_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_startup_defaults();
    test_quality_codes();
    test_rtt_extremes();
    test_random_traffic(0, 0, 360);      // back to back
    test_random_traffic(64, 0, 360);     // bursty sender
    test_random_traffic(0, 64, 360);     // slow receiver
    test_random_traffic(19, 19, 370);    // both sides gapping

    wait_idle();
    repeat (200) @(negedge clk);         // catch any stray record

    $display("run: %0d probes, %0d records checked, %0d register writes, %0d mismatches",
             probes_sent, records_checked, cfg_writes, err_count);
    $display("quality seen: excellent %0d, good %0d, fair %0d, poor jitter %0d, poor loss %0d",
             qual_hist[0], qual_hist[1], qual_hist[2], qual_hist[3], qual_hist[4]);
    if (err_count == 0 && pending_stats.size() == 0) begin
      $display("tb_rtt_jitter_loss_stats_unit OK");
    end else begin
      $display("tb_rtt_jitter_loss_stats_unit NOT OK");
    end
    $finish;
  end

endmodule
